// ----- rtl/sbc_pkg.sv -----
package sbc_pkg;

  localparam int ScrW     = 12;
  localparam int ImgW     = 11;
  localparam int PosW     = 14;
  localparam int AddrW    = 22;
  localparam int PixW     = 16;
  localparam int RegAddrW = 5;
  localparam int DataW    = 32;

  localparam logic [ScrW-1:0] ScreenWidthRst  = 12'd1024;
  localparam logic [ScrW-1:0] ScreenHeightRst = 12'd768;
  localparam logic [ImgW-1:0] ImageWidthRst   = 11'd1;
  localparam logic [ImgW-1:0] ImageHeightRst  = 11'd1;
  localparam logic [PixW-1:0] KeyColorRst     = 16'hF81F;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_ALIGN_MODE    = 3'd6,
    REG_KEY_COLOR     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ALIGN_LEFT = 2'd0,
    ALIGN_MID  = 2'd1,
    ALIGN_END  = 2'd2
  } align_e;

  typedef struct packed {
    logic            start_image;
    logic [PixW-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] pixel_address;
    logic [PixW-1:0]  write_value;
    logic             image_done;
  } out_item_t;

  // Effective settings: sizes already saturated and forced nonzero where required.
  typedef struct packed {
    logic [ScrW-1:0] screen_width;
    logic [ScrW-1:0] screen_height;
    logic [ImgW-1:0] image_width;
    logic [ImgW-1:0] image_height;
    logic [ScrW-1:0] origin_x;
    logic [ScrW-1:0] origin_y;
    logic [1:0]      align_mode;
    logic [PixW-1:0] key_color;
  } cfg_t;

endpackage

// ----- rtl/sbc_regs.sv -----
module sbc_regs #(
  parameter int MAX_SCREEN = 2048,
  parameter int MAX_IMAGE  = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbc_pkg::RegAddrW-1:0]     paddr,
  input  logic [sbc_pkg::DataW-1:0]        pwdata,
  output logic [sbc_pkg::DataW-1:0]        prdata,
  output logic                             pready,
  output sbc_pkg::cfg_t                    cfg_o
);

  localparam int ScrMaxInt = (MAX_SCREEN > 4095) ? 4095 : MAX_SCREEN;
  localparam int ImgMaxInt = (MAX_IMAGE > 2047) ? 2047 : MAX_IMAGE;
  localparam logic [sbc_pkg::ScrW-1:0] ScrMax = sbc_pkg::ScrW'(ScrMaxInt);
  localparam logic [sbc_pkg::ImgW-1:0] ImgMax = sbc_pkg::ImgW'(ImgMaxInt);

  logic [sbc_pkg::ScrW-1:0] screen_width_q, screen_height_q;
  logic [sbc_pkg::ImgW-1:0] image_width_q, image_height_q;
  logic [sbc_pkg::ScrW-1:0] origin_x_q, origin_y_q;
  logic [1:0]               align_mode_q;
  logic [sbc_pkg::PixW-1:0] key_color_q;
  logic                     wr_en;
  sbc_pkg::reg_idx_e        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = sbc_pkg::reg_idx_e'(paddr[sbc_pkg::RegAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= sbc_pkg::ScreenWidthRst;
      screen_height_q <= sbc_pkg::ScreenHeightRst;
      image_width_q   <= sbc_pkg::ImageWidthRst;
      image_height_q  <= sbc_pkg::ImageHeightRst;
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      align_mode_q    <= sbc_pkg::ALIGN_LEFT;
      key_color_q     <= sbc_pkg::KeyColorRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        sbc_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[sbc_pkg::ScrW-1:0];
        sbc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[sbc_pkg::ScrW-1:0];
        sbc_pkg::REG_IMAGE_WIDTH:   image_width_q   <= pwdata[sbc_pkg::ImgW-1:0];
        sbc_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= pwdata[sbc_pkg::ImgW-1:0];
        sbc_pkg::REG_ORIGIN_X:      origin_x_q      <= pwdata[sbc_pkg::ScrW-1:0];
        sbc_pkg::REG_ORIGIN_Y:      origin_y_q      <= pwdata[sbc_pkg::ScrW-1:0];
        sbc_pkg::REG_ALIGN_MODE:    align_mode_q    <= pwdata[1:0];
        sbc_pkg::REG_KEY_COLOR:     key_color_q     <= pwdata[sbc_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sbc_pkg::REG_SCREEN_WIDTH:  prdata = sbc_pkg::DataW'(screen_width_q);
      sbc_pkg::REG_SCREEN_HEIGHT: prdata = sbc_pkg::DataW'(screen_height_q);
      sbc_pkg::REG_IMAGE_WIDTH:   prdata = sbc_pkg::DataW'(image_width_q);
      sbc_pkg::REG_IMAGE_HEIGHT:  prdata = sbc_pkg::DataW'(image_height_q);
      sbc_pkg::REG_ORIGIN_X:      prdata = sbc_pkg::DataW'(origin_x_q);
      sbc_pkg::REG_ORIGIN_Y:      prdata = sbc_pkg::DataW'(origin_y_q);
      sbc_pkg::REG_ALIGN_MODE:    prdata = sbc_pkg::DataW'(align_mode_q);
      sbc_pkg::REG_KEY_COLOR:     prdata = sbc_pkg::DataW'(key_color_q);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.screen_width  = (screen_width_q > ScrMax) ? ScrMax : screen_width_q;
    cfg_o.screen_height = (screen_height_q > ScrMax) ? ScrMax : screen_height_q;
    if (image_width_q == '0) begin
      cfg_o.image_width = sbc_pkg::ImgW'(1);
    end else begin
      cfg_o.image_width = (image_width_q > ImgMax) ? ImgMax : image_width_q;
    end
    if (image_height_q == '0) begin
      cfg_o.image_height = sbc_pkg::ImgW'(1);
    end else begin
      cfg_o.image_height = (image_height_q > ImgMax) ? ImgMax : image_height_q;
    end
    cfg_o.origin_x   = origin_x_q;
    cfg_o.origin_y   = origin_y_q;
    cfg_o.align_mode = align_mode_q;
    cfg_o.key_color  = key_color_q;
  end

endmodule

// ----- rtl/sbc_walk.sv -----
module sbc_walk #(
  parameter int MAX_IMAGE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sbc_pkg::in_item_t               in_item_i,
  input  sbc_pkg::cfg_t                   cfg_i,
  output logic                            pos_valid_o,
  input  logic                            pos_take_i,
  output logic [$clog2(MAX_IMAGE)-1:0]    pos_col_o,
  output logic [$clog2(MAX_IMAGE)-1:0]    pos_row_o,
  output logic [sbc_pkg::PixW-1:0]        pos_pixel_o
);

  localparam int CntW = $clog2(MAX_IMAGE);
  localparam int CmpW = (CntW + 1 > sbc_pkg::ImgW) ? CntW + 1 : sbc_pkg::ImgW;

  logic [CntW-1:0]          col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [CntW-1:0]          cur_col, cur_row;
  logic [CntW:0]            col_inc, row_inc;
  logic                     pos_valid_q;
  logic [CntW-1:0]          col_q, row_q;
  logic [sbc_pkg::PixW-1:0] pixel_q;
  logic                     accept;

  assign in_ready_o = !pos_valid_q || pos_take_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cur_col = in_item_i.start_image ? '0 : col_cnt_q;
  assign cur_row = in_item_i.start_image ? '0 : row_cnt_q;
  assign col_inc = {1'b0, cur_col} + (CntW + 1)'(1);
  assign row_inc = {1'b0, cur_row} + (CntW + 1)'(1);

  always_comb begin
    col_cnt_d = col_inc[CntW-1:0];
    row_cnt_d = cur_row;
    if (CmpW'(col_inc) >= CmpW'(cfg_i.image_width)) begin
      col_cnt_d = '0;
      row_cnt_d = row_inc[CntW-1:0];
      if (CmpW'(row_inc) >= CmpW'(cfg_i.image_height)) begin
        row_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      pos_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      if (in_ready_o) begin
        pos_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q   <= cur_col;
      row_q   <= cur_row;
      pixel_q <= in_item_i.pixel_value;
    end
  end

  assign pos_valid_o = pos_valid_q;
  assign pos_col_o   = col_q;
  assign pos_row_o   = row_q;
  assign pos_pixel_o = pixel_q;

endmodule

// ----- rtl/sbc_map.sv -----
module sbc_map #(
  parameter int MAX_IMAGE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sbc_pkg::cfg_t                   cfg_i,
  input  logic                            pos_valid_i,
  output logic                            pos_take_o,
  input  logic [$clog2(MAX_IMAGE)-1:0]    pos_col_i,
  input  logic [$clog2(MAX_IMAGE)-1:0]    pos_row_i,
  input  logic [sbc_pkg::PixW-1:0]        pos_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sbc_pkg::out_item_t              out_item_o
);

  localparam int CntW = $clog2(MAX_IMAGE);
  localparam int PosW = sbc_pkg::PosW;
  localparam int ScrW = sbc_pkg::ScrW;
  localparam int CmpW = (CntW > sbc_pkg::ImgW) ? CntW : sbc_pkg::ImgW;

  logic [PosW-1:0]          align_off, ax, ox_ext, oy_ext, col_s, row_s, col_ext, row_ext;
  logic [PosW-1:0]          width_ext, height_ext;
  logic                     on_screen, wr_en, done;
  logic [2*ScrW-1:0]        prod, addr_sum;
  logic                     out_valid_q;
  sbc_pkg::out_item_t       out_item_q, out_item_d;

  assign pos_take_o = !out_valid_q || out_ready_i;

  assign ox_ext     = {{(PosW - ScrW){cfg_i.origin_x[ScrW-1]}}, cfg_i.origin_x};
  assign oy_ext     = {{(PosW - ScrW){cfg_i.origin_y[ScrW-1]}}, cfg_i.origin_y};
  assign width_ext  = PosW'(cfg_i.image_width);
  assign height_ext = PosW'(cfg_i.image_height);
  assign col_ext    = {{(PosW - CntW){1'b0}}, pos_col_i};
  assign row_ext    = {{(PosW - CntW){1'b0}}, pos_row_i};

  always_comb begin
    case (cfg_i.align_mode)
      sbc_pkg::ALIGN_MID: align_off = PosW'(cfg_i.image_width >> 1);
      sbc_pkg::ALIGN_END: align_off = width_ext;
      default:            align_off = '0;
    endcase
  end

  assign ax    = ox_ext - align_off;
  assign col_s = ax + col_ext;
  assign row_s = oy_ext + height_ext - PosW'(1) - row_ext;

  assign on_screen = !col_s[PosW-1] && (col_s < PosW'(cfg_i.screen_width)) &&
                     !row_s[PosW-1] && (row_s < PosW'(cfg_i.screen_height));
  assign wr_en     = on_screen && (pos_pixel_i != cfg_i.key_color);

  assign prod     = row_s[ScrW-1:0] * cfg_i.screen_width;
  assign addr_sum = prod + (2 * ScrW)'(col_s[ScrW-1:0]);

  assign done = (CmpW'(pos_col_i) == CmpW'(cfg_i.image_width - sbc_pkg::ImgW'(1))) &&
                (CmpW'(pos_row_i) == CmpW'(cfg_i.image_height - sbc_pkg::ImgW'(1)));

  always_comb begin
    out_item_d.write_enable  = wr_en;
    out_item_d.pixel_address = wr_en ? addr_sum[sbc_pkg::AddrW-1:0] : '0;
    out_item_d.write_value   = wr_en ? pos_pixel_i : '0;
    out_item_d.image_done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pos_take_o) begin
      out_valid_q <= pos_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_take_o && pos_valid_i) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/sprite_blit_clip_colorkey.sv -----
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o   in_item_i  (start_image, pixel_value)
// out       output     out_valid_o / out_ready_i out_item_o (write_enable, pixel_address,
//                                                            write_value, image_done)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per clock unless the output stalls; the result register offers each result.
// The rate is set by the input register and the result register, which hold one item each.
// Reset clears the pixel counters and both valid flags and loads the register defaults.
// A stalled output holds its item while the input register can still take one item.
module sprite_blit_clip_colorkey #(
  parameter int MAX_SCREEN = 2048,
  parameter int MAX_IMAGE  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sbc_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sbc_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbc_pkg::RegAddrW-1:0]  paddr,
  input  logic [sbc_pkg::DataW-1:0]     pwdata,
  output logic [sbc_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  localparam int CntW = $clog2(MAX_IMAGE);

  sbc_pkg::cfg_t            cfg;
  logic                     pos_valid, pos_take;
  logic [CntW-1:0]          pos_col, pos_row;
  logic [sbc_pkg::PixW-1:0] pos_pixel;

  sbc_regs #(
    .MAX_SCREEN(MAX_SCREEN),
    .MAX_IMAGE (MAX_IMAGE)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  sbc_walk #(
    .MAX_IMAGE(MAX_IMAGE)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .pos_valid_o(pos_valid),
    .pos_take_i (pos_take),
    .pos_col_o  (pos_col),
    .pos_row_o  (pos_row),
    .pos_pixel_o(pos_pixel)
  );

  sbc_map #(
    .MAX_IMAGE(MAX_IMAGE)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pos_valid_i(pos_valid),
    .pos_take_o (pos_take),
    .pos_col_i  (pos_col),
    .pos_row_i  (pos_row),
    .pos_pixel_i(pos_pixel),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- rtl/sbc_check.sv -----
module sbc_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input sbc_pkg::out_item_t            out_item_o,
  input logic                          psel,
  input logic                          pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed or dropped");

  a_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.write_enable |->
      out_item_o.pixel_address == '0 && out_item_o.write_value == '0)
    else $error("masked item carries address or value");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output item appeared without an input item two cycles earlier");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("register port stalled");

endmodule

bind sprite_blit_clip_colorkey sbc_check u_sbc_check (.*);
